@@ hw/rtl/ctrc_pkg.sv @@
// Shared constants, types and register codes for the counter tick rate converter.
package ctrc_pkg;

    // Fixed field widths.
    localparam int FREQ_W      = 41;
    localparam int RATE_W      = 20;
    localparam int VALUE_W     = 64;
    localparam int TICKS_W     = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 8;

    // Defaults for the top-level parameters.
    localparam int COUNTER_WIDTH_DEF = 64;
    localparam int TICK_WIDTH_DEF    = 32;

    // Register reset values.
    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(10000000);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(100000);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_FREQ     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_RATE     = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_WATCHDOG = CFG_INDEX_W'(3);

    // Input operation codes.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // Sequencer states of the conversion core.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_MULQ,
        ST_MULR,
        ST_DIV2,
        ST_SUM,
        ST_DONE
    } ctrc_state_t;

    // Status the core reports to the top level.
    typedef struct packed {
        logic idle;
        logic done;
    } ctrc_status_t;

endpackage

@@ hw/rtl/ctrc_divstep.sv @@
// One restoring division step: shift in a dividend bit, compare and subtract.
module ctrc_divstep
    import ctrc_pkg::*;
#(
    parameter int DIV_W = FREQ_W
)
(
    input  logic [DIV_W-1:0] rem,
    input  logic             bit_in,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] rem_out,
    output logic             q_bit
);

    logic [DIV_W:0] shifted;
    logic [DIV_W:0] trial;

    // The partial remainder stays below the divisor, so the result fits DIV_W bits.
    assign shifted = {rem, bit_in};
    assign trial   = shifted - {1'b0, divisor};
    assign q_bit   = (shifted >= {1'b0, divisor});
    assign rem_out = q_bit ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];

endmodule

@@ hw/rtl/ctrc_core.sv @@
// Sequenced conversion core: shared divide step and shared multiplier.
module ctrc_core
    import ctrc_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
    parameter int TICK_WIDTH    = TICK_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     take,
    input  logic [COUNTER_WIDTH-1:0] sample,
    input  logic [COUNTER_WIDTH-1:0] origin,
    input  logic [FREQ_W-1:0]        freq,
    input  logic [RATE_W-1:0]        rate,
    output ctrc_status_t             status,
    output logic [TICK_WIDTH-1:0]    result
);

    localparam int CNT_W  = $clog2(COUNTER_WIDTH);
    localparam int PROD_W = FREQ_W + RATE_W;
    localparam int SUM_W  = (TICK_WIDTH > RATE_W) ? TICK_WIDTH : RATE_W;

    ctrc_state_t state_reg, state_next;

    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [FREQ_W-1:0]        rem_reg, rem_next;
    logic [COUNTER_WIDTH-1:0] qsh_reg, qsh_next;
    logic [TICK_WIDTH-1:0]    whole_reg, whole_next;
    logic [TICK_WIDTH-1:0]    result_reg, result_next;

    logic              step_bit;
    logic [FREQ_W-1:0] step_rem;
    logic              step_q;
    logic [FREQ_W-1:0] mul_a;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;

    // Shared divide step; the dividend bit comes from the top of the active field.
    assign step_bit = (state_reg == ST_DIV2) ? qsh_reg[RATE_W-1] : qsh_reg[COUNTER_WIDTH-1];

    ctrc_divstep #(
        .DIV_W (FREQ_W)
    ) u_divstep (
        .rem     (rem_reg),
        .bit_in  (step_bit),
        .divisor (freq),
        .rem_out (step_rem),
        .q_bit   (step_q)
    );

    // Shared multiplier: low quotient bits first, then the remainder.
    assign mul_a = (state_reg == ST_MULQ) ? FREQ_W'(qsh_reg[TICK_WIDTH-1:0]) : rem_reg;
    assign prod  = {{RATE_W{1'b0}}, mul_a} * {{FREQ_W{1'b0}}, rate};

    // Whole-seconds ticks plus the fractional ticks.
    assign sum = SUM_W'(whole_reg) + SUM_W'(qsh_reg[RATE_W-1:0]);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_MULQ;
                end
            end
            ST_MULQ: state_next = ST_MULR;
            ST_MULR: state_next = ST_DIV2;
            ST_DIV2:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: state_next = ST_DONE;
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Status outputs.
    always_comb
    begin
        status.idle = 1'b0;
        status.done = 1'b0;
        unique case (state_reg)
            ST_IDLE: status.idle = 1'b1;
            ST_DONE: status.done = 1'b1;
            default:
            begin
                status.idle = 1'b0;
                status.done = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        qsh_next    = qsh_reg;
        whole_next  = whole_reg;
        result_next = result_reg;
        case (state_reg) inside
            ST_IDLE:
            begin
                // Load the distance from the origin, wrapped to the counter width.
                if (start)
                begin
                    cnt_next = CNT_W'(COUNTER_WIDTH - 1);
                    rem_next = '0;
                    qsh_next = sample - origin;
                end
            end
            ST_DIV1, ST_DIV2:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                rem_next = step_rem;
                qsh_next = {qsh_reg[COUNTER_WIDTH-2:0], step_q};
            end
            ST_MULQ:
            begin
                whole_next = prod[TICK_WIDTH-1:0];
            end
            ST_MULR:
            begin
                // The upper part of the product is already below the divisor.
                cnt_next = CNT_W'(RATE_W - 1);
                rem_next = prod[PROD_W-1:RATE_W];
                qsh_next = COUNTER_WIDTH'(prod[RATE_W-1:0]);
            end
            ST_SUM:
            begin
                result_next = sum[TICK_WIDTH-1:0];
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        qsh_reg    <= qsh_next;
        whole_reg  <= whole_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

@@ hw/rtl/counter_tick_rate_converter_unit.sv @@
// One item at a time: the core takes no new item until its result moves to the output register.
// The radix-2 divide step runs over every counter bit and then over 20 fraction bits.
// A finished result waits in the output register while the next item is taken.
// Reset restores the register defaults, clears the anchor and empties the output register.
module counter_tick_rate_converter_unit
    import ctrc_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
    parameter int TICK_WIDTH    = TICK_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   operation,
    input  logic [VALUE_W-1:0]     counter_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [TICKS_W-1:0]     ticks,
    output logic                   reanchored
);

    localparam logic [TICK_WIDTH-1:0] SPAN = {2'b11, {(TICK_WIDTH-2){1'b0}}};

    logic [FREQ_W-1:0]        freq_reg, freq_next;
    logic [COUNTER_WIDTH-1:0] origin_reg, origin_next;
    logic [RATE_W-1:0]        rate_reg, rate_next;
    logic                     wd_reg, wd_next;
    logic [TICK_WIDTH-1:0]    anchor_reg, anchor_next;
    logic                     op_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [TICK_WIDTH-1:0]    ticks_reg;
    logic                     reanchored_reg;

    ctrc_status_t          core_status;
    logic [TICK_WIDTH-1:0] core_result;
    logic                  in_fire;
    logic                  cfg_fire;
    logic                  take;
    logic [TICK_WIDTH-1:0] anchor_gap;
    logic                  hit;
    logic [FREQ_W-1:0]     freq_data;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = core_status.idle;
    assign in_fire   = in_valid && in_ready;

    // A finished result moves out when the output register is free.
    assign take = core_status.done && (!out_valid_reg || out_ready);

    ctrc_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .TICK_WIDTH    (TICK_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_fire),
        .take   (take),
        .sample (counter_value[COUNTER_WIDTH-1:0]),
        .origin (origin_reg),
        .freq   (freq_reg),
        .rate   (rate_reg),
        .status (core_status),
        .result (core_result)
    );

    // Configuration decode; a zero frequency is stored as one.
    assign freq_data = cfg_data[FREQ_W-1:0];

    always_comb
    begin
        freq_next   = freq_reg;
        origin_next = origin_reg;
        rate_next   = rate_reg;
        wd_next     = wd_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_FREQ:     freq_next   = (freq_data == '0) ? FREQ_W'(1) : freq_data;
                REG_ORIGIN:   origin_next = cfg_data[COUNTER_WIDTH-1:0];
                REG_RATE:     rate_next   = cfg_data[RATE_W-1:0];
                REG_WATCHDOG: wd_next     = cfg_data[0];
                default:      wd_next     = wd_reg;
            endcase
        end
    end

    // Re-anchor test on the wrapped distance since the anchor.
    assign anchor_gap = core_result - anchor_reg;
    assign hit        = (op_reg == OP_FRAME) && wd_reg && (anchor_gap >= SPAN);

    always_comb
    begin
        anchor_next    = anchor_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
            if (hit)
            begin
                anchor_next = core_result;
            end
        end
    end

    // Control and configuration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg      <= FREQ_RESET;
            origin_reg    <= '0;
            rate_reg      <= RATE_RESET;
            wd_reg        <= 1'b0;
            anchor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            freq_reg      <= freq_next;
            origin_reg    <= origin_next;
            rate_reg      <= rate_next;
            wd_reg        <= wd_next;
            anchor_reg    <= anchor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg <= operation;
        end
        if (take)
        begin
            ticks_reg      <= core_result;
            reanchored_reg <= hit;
        end
    end

    assign out_valid  = out_valid_reg;
    assign ticks      = TICKS_W'(ticks_reg);
    assign reanchored = reanchored_reg;

    // The core stays busy after it takes an item.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input ready while an item is in progress");

    // A reported re-anchor leaves the anchor at the reported ticks.
    a_anchor_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && reanchored_reg) |-> (anchor_reg == ticks_reg))
        else $error("anchor does not match re-anchored ticks");

    // With the watchdog off no result can report a re-anchor.
    a_no_reanchor_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !wd_reg) |=> (!reanchored_reg && $stable(anchor_reg)))
        else $error("re-anchor with watchdog disabled");

endmodule

@@ test/tb_counter_tick_rate_converter_unit.sv @@
// Self-checking testbench for the counter tick rate converter unit.
`timescale 1ns / 100ps

module tb_counter_tick_rate_converter_unit;
    import ctrc_pkg::*;

    // Distance from the anchor at which a frame check moves the anchor.
    localparam logic [TICKS_W-1:0] REANCHOR_SPAN = 32'hC000_0000;
    // A register index that the block must ignore.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(7);
    localparam int PLAN_N = 25;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 75;

    typedef struct packed {
        logic [TICKS_W-1:0] ticks;
        logic               reanchored;
    } tick_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // One row of the directed plan: an item or a register write.
    typedef struct {
        row_kind_t              kind;
        logic                   op;
        logic [CFG_INDEX_W-1:0] index;
        logic [VALUE_W-1:0]     data;
        logic                   fixed_given;
        tick_result_t           fixed_result;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   operation = OP_READ;
    logic [VALUE_W-1:0]     counter_value = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b1;
    logic [TICKS_W-1:0]     ticks;
    logic                   reanchored;

    // Shadow copy of the configuration and the anchor.
    logic [FREQ_W-1:0]  div_freq = FREQ_RESET;
    logic [VALUE_W-1:0] zero_point = '0;
    logic [RATE_W-1:0]  out_rate = RATE_RESET;
    logic               guard_on = 1'b0;
    logic [TICKS_W-1:0] last_anchor = '0;

    tick_result_t tick_results_q[$];
    int           mismatches = 0;
    logic         quiet = 1'b0;

    // Directed plan: reset defaults, the re-anchor threshold, origin wrap and extremes.
    plan_row_t plan [PLAN_N] = '{
        '{ROW_ITEM, OP_READ,  '0, 64'd0,                  1'b1, '{32'd0, 1'b0}},
        '{ROW_ITEM, OP_READ,  '0, 64'd100,                1'b1, '{32'd1, 1'b0}},
        '{ROW_ITEM, OP_READ,  '0, 64'd10_000_000,         1'b1, '{32'd100_000, 1'b0}},
        '{ROW_ITEM, OP_FRAME, '0, 64'd50_000_000,         1'b1, '{32'd500_000, 1'b0}},
        '{ROW_ITEM, OP_READ,  '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '{32'd0, 1'b0}},
        '{ROW_ITEM, OP_FRAME, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '{32'd0, 1'b0}},
        '{ROW_CFG,  OP_READ,  REG_WATCHDOG, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '{32'd0, 1'b0}},
        '{ROW_CFG,  OP_READ,  REG_FREQ,     64'd0,                  1'b0, '{32'd0, 1'b0}},
        '{ROW_CFG,  OP_READ,  REG_RATE,     64'hFFFF_FFFF_FFF0_0001, 1'b0, '{32'd0, 1'b0}},
        '{ROW_ITEM, OP_FRAME, '0, 64'h0000_0000_BFFF_FFFF, 1'b1, '{32'hBFFF_FFFF, 1'b0}},
        '{ROW_ITEM, OP_FRAME, '0, 64'h0000_0000_C000_0000, 1'b1, '{32'hC000_0000, 1'b1}},
        '{ROW_ITEM, OP_FRAME, '0, 64'h0000_0000_C000_0000, 1'b1, '{32'hC000_0000, 1'b0}},
        '{ROW_ITEM, OP_FRAME, '0, 64'h0000_0000_8000_0000, 1'b1, '{32'h8000_0000, 1'b1}},
        '{ROW_ITEM, OP_FRAME, '0, 64'h0000_0001_3FFF_FFFF, 1'b1, '{32'h3FFF_FFFF, 1'b0}},
        '{ROW_ITEM, OP_READ,  '0, 64'h0000_0007_4000_0000, 1'b1, '{32'h4000_0000, 1'b0}},
        '{ROW_CFG,  OP_READ,  REG_ORIGIN,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '{32'd0, 1'b0}},
        '{ROW_ITEM, OP_READ,  '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{32'd0, 1'b0}},
        '{ROW_ITEM, OP_READ,  '0, 64'd5,                  1'b1, '{32'd6, 1'b0}},
        '{ROW_CFG,  OP_READ,  REG_RATE,     64'h0000_0000_000F_FFFF, 1'b0, '{32'd0, 1'b0}},
        '{ROW_CFG,  OP_READ,  REG_FREQ,     64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '{32'd0, 1'b0}},
        '{ROW_CFG,  OP_READ,  REG_UNUSED,   64'd0,                  1'b0, '{32'd0, 1'b0}},
        '{ROW_ITEM, OP_FRAME, '0, 64'h8000_0000_0000_0000, 1'b0, '{32'd0, 1'b0}},
        '{ROW_ITEM, OP_READ,  '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '{32'd0, 1'b0}},
        '{ROW_CFG,  OP_READ,  REG_FREQ,     64'd1,                  1'b0, '{32'd0, 1'b0}},
        '{ROW_ITEM, OP_FRAME, '0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '{32'd0, 1'b0}}
    };

    counter_tick_rate_converter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .counter_value (counter_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ticks         (ticks),
        .reanchored    (reanchored)
    );

    always #10 clk = ~clk;

    // Converts a raw sample to ticks with the shadow configuration.
    function automatic logic [TICKS_W-1:0] counter_to_ticks(input logic [VALUE_W-1:0] sample);
        logic [63:0] freq;
        logic [63:0] rate;
        logic [63:0] diff;
        logic [63:0] whole;
        logic [63:0] part;
        freq  = (div_freq == '0) ? 64'd1 : 64'(div_freq);
        rate  = 64'(out_rate);
        diff  = sample - zero_point;
        whole = (diff / freq) * rate;
        part  = ((diff % freq) * rate) / freq;
        return TICKS_W'(whole + part);
    endfunction

    // Works out the result of one item and moves the anchor when a frame check asks for it.
    function automatic tick_result_t advance_timebase(input logic op,
                                                      input logic [VALUE_W-1:0] sample);
        tick_result_t res;
        logic [TICKS_W-1:0] anchor_gap;
        res.ticks = counter_to_ticks(sample);
        res.reanchored = 1'b0;
        anchor_gap = res.ticks - last_anchor;
        if (op == OP_FRAME && guard_on && anchor_gap >= REANCHOR_SPAN)
        begin
            last_anchor = res.ticks;
            res.reanchored = 1'b1;
        end
        return res;
    endfunction

    // Mirrors a register write into the shadow configuration.
    function automatic void note_register(input logic [CFG_INDEX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_FREQ:     div_freq = data[FREQ_W-1:0];
            REG_ORIGIN:   zero_point = data;
            REG_RATE:     out_rate = data[RATE_W-1:0];
            REG_WATCHDOG: guard_on = data[0];
            default:      ;
        endcase
    endfunction

    // Result checker: each accepted result against the oldest outstanding one.
    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (tick_results_q.size() == 0)
            begin
                $display("%0t: result with none outstanding: expected none, %s %h %s %b",
                         $time, "actual ticks", ticks, "reanchored", reanchored);
                mismatches++;
            end
            else
            begin
                want = tick_results_q.pop_front();
                if (ticks !== want.ticks)
                begin
                    $display("%0t: ticks mismatch: expected %h, actual %h",
                             $time, want.ticks, ticks);
                    mismatches++;
                end
                if (reanchored !== want.reanchored)
                begin
                    $display("%0t: reanchored mismatch: expected %b, actual %b",
                             $time, want.reanchored, reanchored);
                    mismatches++;
                end
            end
        end
    end

    // Receiver stalls now and then, except during the quiet stretch.
    always @(posedge clk)
        out_ready <= quiet || ($urandom_range(99) >= 6);

    // Offers one item, waits for its acceptance and records its result.
    task automatic send_item(input logic op, input logic [VALUE_W-1:0] sample,
                             input logic fixed_given, input tick_result_t fixed_result);
        tick_result_t got;
        while (!quiet && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        counter_value <= sample;
        do @(posedge clk); while (!in_ready);
        got = advance_timebase(op, sample);
        tick_results_q.push_back(fixed_given ? fixed_result : got);
    endtask

    // Stops sending and waits until every outstanding result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tick_results_q.size() != 0)
            @(posedge clk);
    endtask

    // Writes one register; only called while the block is idle.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        note_register(index, data);
        @(posedge clk);
    endtask

    // Picks a fresh setting of every register for one random phase.
    task automatic configure_phase(input int phase);
        logic [CFG_DATA_W-1:0] data;
        int pick;
        pick = (phase == 0) ? 2 : (phase == 1) ? 0 : $urandom_range(5);
        case (pick)
            0:       data = 64'd0;
            1:       data = 64'd1;
            2:       data = {$urandom, $urandom} | 64'h1FF_FFFF_FFFF;
            3:       data = 64'd10_000_000;
            4:       data = 64'($urandom_range(1000, 100_000));
            default: data = {$urandom, $urandom};
        endcase
        write_register(REG_FREQ, data);

        pick = (phase == 0) ? 1 : (phase == 1) ? 0 : $urandom_range(4);
        case (pick)
            0:       data = 64'd1000;
            1:       data = 64'd1_000_000;
            2:       data = {$urandom, $urandom};
            3:       data = 64'd0;
            default: data = 64'($urandom_range(1000, 1_000_000));
        endcase
        write_register(REG_RATE, data);

        case ($urandom_range(2))
            0:       data = 64'd0;
            1:       data = 64'hFFFF_FFFF_FFFF_FFFF;
            default: data = {$urandom, $urandom};
        endcase
        write_register(REG_ORIGIN, data);

        data = {$urandom, $urandom};
        data[0] = ($urandom_range(3) != 0);
        write_register(REG_WATCHDOG, data);

        // Writes to indexes past the last register must leave everything alone.
        if ($urandom_range(1) == 1)
            write_register(CFG_INDEX_W'($urandom_range(REG_WATCHDOG + 1, 255)),
                           {$urandom, $urandom});
    endtask

    // Stimulus: reset, the directed plan, then random phases.
    initial
    begin
        logic [VALUE_W-1:0] sample;
        logic [VALUE_W-1:0] free_run;
        logic               op;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_results();
                write_register(plan[i].index, plan[i].data);
            end
            else
            begin
                send_item(plan[i].op, plan[i].data, plan[i].fixed_given, plan[i].fixed_result);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            quiet = (phase == 2);
            configure_phase(phase);
            free_run = zero_point;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Mostly a counter that runs forward, with stray samples mixed in.
                case ($urandom_range(3))
                    0:       sample = {$urandom, $urandom};
                    1:       sample = zero_point + {32'($urandom_range(255)), $urandom};
                    default:
                    begin
                        free_run = free_run + {32'($urandom_range(1023)), $urandom};
                        sample = free_run;
                    end
                endcase
                op = ($urandom_range(1) == 1) ? OP_FRAME : OP_READ;
                send_item(op, sample, 1'b0, '0);
            end
        end
        quiet = 1'b0;

        drain_results();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
